// ===== hw/rtl/srwt_pkg.sv =====
// Shared types and codes for the selective repeat window tracker.
// Used by srwt_ctrl, srwt_datapath and the top level; no dependencies.
package srwt_pkg;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_RECV  = 3'd1;
    localparam logic [2:0] OP_SAVE  = 3'd2;
    localparam logic [2:0] OP_SLIDE = 3'd3;
    localparam logic [2:0] OP_REQ   = 3'd4;

    localparam logic [1:0] ST_NOT_ACTIVE = 2'd0;
    localparam logic [1:0] ST_SENT       = 2'd1;
    localparam logic [1:0] ST_RECEIVED   = 2'd2;
    localparam logic [1:0] ST_SAVED      = 2'd3;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_RECV  = 2'd1;
    localparam logic [1:0] KIND_SLIDE = 2'd2;
    localparam logic [1:0] KIND_REQ   = 2'd3;

    localparam logic [1:0] CFG_TOTAL = 2'd0;
    localparam logic [1:0] CFG_WIN   = 2'd1;

    typedef logic [4:0] t_uop;
    localparam t_uop UOP_NOP       = 5'd0;
    localparam t_uop UOP_CAP       = 5'd1;
    localparam t_uop UOP_CLR       = 5'd2;
    localparam t_uop UOP_INIT_WR   = 5'd3;
    localparam t_uop UOP_RD        = 5'd4;
    localparam t_uop UOP_RD_SRC    = 5'd5;
    localparam t_uop UOP_INC       = 5'd6;
    localparam t_uop UOP_RCV_HIT   = 5'd7;
    localparam t_uop UOP_SAVE_HIT  = 5'd8;
    localparam t_uop UOP_LEAD_INC  = 5'd9;
    localparam t_uop UOP_SL_SETUP  = 5'd10;
    localparam t_uop UOP_BASE_LD   = 5'd11;
    localparam t_uop UOP_CP_WR     = 5'd12;
    localparam t_uop UOP_NEW_WR    = 5'd13;
    localparam t_uop UOP_Q_HIT     = 5'd14;
    localparam t_uop UOP_EMIT_LAST = 5'd15;
    localparam t_uop UOP_PEND_LAST = 5'd16;

    typedef struct packed {
        logic [31:0] off;
        logic [9:0]  len;
        logic [1:0]  st;
    } t_slot;

    typedef struct packed {
        logic [2:0] op;
        logic       out_busy;
        logic       last_idx;
        logic       clr_last;
        logic       in_win;
        logic       match;
        logic       saved;
        logic       received;
        logic       eligible;
        logic       lead_zero;
        logic       cp_copy;
        logic       pend_valid;
    } t_stat;

endpackage

// ===== hw/rtl/selective_repeat_window_tracker_core.sv =====
// Top level of the selective repeat window tracker: controller plus datapath.
// Depends on srwt_pkg, srwt_ctrl and srwt_datapath.
//
// After reset the block clears its slot memory, one slot a cycle, before it
// takes the first item; config writes are taken at any time. All slots live
// in one single-port memory with a registered read, and that port sets the
// pace: init writes each of the ws slots in use in turn, save reads one slot,
// receive and request read and check each slot visited, slide counts the
// leading saved slots, then copies or refills each slot of the window. Request
// emits one beat per eligible slot (one beat if none) and waits on the output
// register when the consumer stalls.
module selective_repeat_window_tracker_core #(
    parameter int SEGMENT_BYTES = 1000,
    parameter int MAX_SLOTS     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_seg_start,
    input  logic [9:0]  i_seg_length,
    input  logic [5:0]  i_slot_index,
    input  logic [22:0] i_segment_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic        o_hit,
    output logic [5:0]  o_hit_slot,
    output logic [31:0] o_req_start,
    output logic [9:0]  o_req_length,
    output logic [6:0]  o_slide_amount,
    output logic [22:0] o_segments_remaining,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import srwt_pkg::*;

    t_stat stat;
    t_uop  uop;

    assign o_cfg_ready = 1'b1;

    srwt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_uop   (uop)
    );

    srwt_datapath #(
        .SEGMENT_BYTES (SEGMENT_BYTES),
        .MAX_SLOTS     (MAX_SLOTS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_uop                (uop),
        .o_stat               (stat),
        .i_opcode             (i_opcode),
        .i_seg_start          (i_seg_start),
        .i_seg_length         (i_seg_length),
        .i_slot_index         (i_slot_index),
        .i_segment_count      (i_segment_count),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_result_kind        (o_result_kind),
        .o_hit                (o_hit),
        .o_hit_slot           (o_hit_slot),
        .o_req_start          (o_req_start),
        .o_req_length         (o_req_length),
        .o_slide_amount       (o_slide_amount),
        .o_segments_remaining (o_segments_remaining),
        .o_last               (o_last)
    );

endmodule

// ===== hw/rtl/srwt_ctrl.sv =====
// Sequencer for the window tracker: one micro-op per cycle to the datapath.
// Depends on srwt_pkg.
module srwt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  srwt_pkg::t_stat i_stat,
    output srwt_pkg::t_uop  o_uop
);
    import srwt_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_INIT  = 5'd3;
    localparam logic [4:0] S_RRD   = 5'd4;
    localparam logic [4:0] S_RCK   = 5'd5;
    localparam logic [4:0] S_SRD   = 5'd6;
    localparam logic [4:0] S_SCK   = 5'd7;
    localparam logic [4:0] S_LRD   = 5'd8;
    localparam logic [4:0] S_LCK   = 5'd9;
    localparam logic [4:0] S_LDONE = 5'd10;
    localparam logic [4:0] S_BRD   = 5'd11;
    localparam logic [4:0] S_BCK   = 5'd12;
    localparam logic [4:0] S_CP    = 5'd13;
    localparam logic [4:0] S_CPW   = 5'd14;
    localparam logic [4:0] S_QRD   = 5'd15;
    localparam logic [4:0] S_QCK   = 5'd16;
    localparam logic [4:0] S_QEND  = 5'd17;
    localparam logic [4:0] S_EMIT  = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_uop   = UOP_NOP;
        unique case (r_state)
            S_CLR: begin
                o_uop = UOP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_uop   = UOP_CAP;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    OP_INIT:  n_state = S_INIT;
                    OP_RECV:  n_state = S_RRD;
                    OP_SAVE:  n_state = i_stat.in_win ? S_SRD : S_EMIT;
                    OP_SLIDE: n_state = S_LRD;
                    OP_REQ:   n_state = i_stat.in_win ? S_QRD : S_QEND;
                    default:  n_state = S_EMIT;
                endcase
            end
            S_INIT: begin
                o_uop = UOP_INIT_WR;
                if (i_stat.last_idx) n_state = S_EMIT;
            end
            S_RRD: begin
                o_uop   = UOP_RD;
                n_state = S_RCK;
            end
            S_RCK: begin
                if (i_stat.match) begin
                    o_uop   = UOP_RCV_HIT;
                    n_state = S_EMIT;
                end else if (i_stat.last_idx) begin
                    n_state = S_EMIT;
                end else begin
                    o_uop   = UOP_INC;
                    n_state = S_RRD;
                end
            end
            S_SRD: begin
                o_uop   = UOP_RD;
                n_state = S_SCK;
            end
            S_SCK: begin
                if (i_stat.received) o_uop = UOP_SAVE_HIT;
                n_state = S_EMIT;
            end
            S_LRD: begin
                o_uop   = UOP_RD;
                n_state = S_LCK;
            end
            S_LCK: begin
                if (i_stat.saved) begin
                    o_uop   = UOP_LEAD_INC;
                    n_state = i_stat.last_idx ? S_LDONE : S_LRD;
                end else begin
                    n_state = S_LDONE;
                end
            end
            S_LDONE: begin
                if (i_stat.lead_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_uop   = UOP_SL_SETUP;
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                o_uop   = UOP_RD;
                n_state = S_BCK;
            end
            S_BCK: begin
                o_uop   = UOP_BASE_LD;
                n_state = S_CP;
            end
            S_CP: begin
                if (i_stat.cp_copy) begin
                    o_uop   = UOP_RD_SRC;
                    n_state = S_CPW;
                end else begin
                    o_uop = UOP_NEW_WR;
                    if (i_stat.last_idx) n_state = S_EMIT;
                end
            end
            S_CPW: begin
                o_uop   = UOP_CP_WR;
                n_state = i_stat.last_idx ? S_EMIT : S_CP;
            end
            S_QRD: begin
                o_uop   = UOP_RD;
                n_state = S_QCK;
            end
            S_QCK: begin
                if (i_stat.eligible) begin
                    if (!(i_stat.pend_valid && i_stat.out_busy)) begin
                        o_uop   = UOP_Q_HIT;
                        n_state = i_stat.last_idx ? S_QEND : S_QRD;
                    end
                end else if (i_stat.last_idx) begin
                    n_state = S_QEND;
                end else begin
                    o_uop   = UOP_INC;
                    n_state = S_QRD;
                end
            end
            S_QEND: begin
                if (!i_stat.out_busy) begin
                    o_uop   = i_stat.pend_valid ? UOP_PEND_LAST : UOP_EMIT_LAST;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_uop   = UOP_EMIT_LAST;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end

endmodule

// ===== hw/rtl/srwt_datapath.sv =====
// Slot memory, counters, config registers and result register of the tracker.
// Executes micro-ops from srwt_ctrl; depends on srwt_pkg.
module srwt_datapath #(
    parameter int SEGMENT_BYTES = 1000,
    parameter int MAX_SLOTS     = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srwt_pkg::t_uop  i_uop,
    output srwt_pkg::t_stat o_stat,
    input  logic [2:0]      i_opcode,
    input  logic [31:0]     i_seg_start,
    input  logic [9:0]      i_seg_length,
    input  logic [5:0]      i_slot_index,
    input  logic [22:0]     i_segment_count,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_result_kind,
    output logic            o_hit,
    output logic [5:0]      o_hit_slot,
    output logic [31:0]     o_req_start,
    output logic [9:0]      o_req_length,
    output logic [6:0]      o_slide_amount,
    output logic [22:0]     o_segments_remaining,
    output logic            o_last
);
    import srwt_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int WW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (WW > 7) ? WW : 7;

    t_slot       r_mem [MAX_SLOTS];
    t_slot       r_rd;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    t_slot       wr_data;
    logic        rd_en;
    logic [IW-1:0] rd_addr;

    logic [31:0]   r_total;
    logic [6:0]    r_win;
    logic [2:0]    r_op;
    logic [31:0]   r_sstart;
    logic [9:0]    r_slen;
    logic [IW-1:0] r_idx;
    logic [WW-1:0] r_lead;
    logic [WW-1:0] r_slide;
    logic [22:0]   r_segs;
    logic [31:0]   r_base;
    logic          r_res_hit;
    logic [IW-1:0] r_res_slot;
    logic          r_pend_valid;
    logic [IW-1:0] r_pend_slot;
    logic [31:0]   r_pend_off;
    logic [9:0]    r_pend_len;

    logic [WW-1:0] ws;
    logic [CW-1:0] win_ext;
    logic [9:0]    base_len;
    logic [32:0]   st_sum;
    logic [31:0]   st_new;
    logic [9:0]    st_len;
    logic [WW-1:0] slide_sel;

    logic          push_en;
    logic [1:0]    push_kind;
    logic          push_hit;
    logic [5:0]    push_slot;
    logic [31:0]   push_start;
    logic [9:0]    push_len;
    logic [6:0]    push_slide;
    logic          push_last;

    function automatic logic [9:0] clamp_len(input logic [31:0] off, input logic [31:0] tot);
        logic [31:0] diff;
        diff = tot - off;
        if (off >= tot)                    clamp_len = 10'd0;
        else if (diff > 32'(SEGMENT_BYTES)) clamp_len = 10'(SEGMENT_BYTES);
        else                               clamp_len = diff[9:0];
    endfunction

    function automatic logic [1:0] kind_of(input logic [2:0] op);
        case (op)
            OP_RECV:  kind_of = KIND_RECV;
            OP_SLIDE: kind_of = KIND_SLIDE;
            OP_REQ:   kind_of = KIND_REQ;
            default:  kind_of = KIND_DONE;
        endcase
    endfunction

    always_comb begin
        win_ext = CW'(r_win);
        if (r_win == 7'd0)                   ws = WW'(1);
        else if (win_ext > CW'(MAX_SLOTS))   ws = WW'(MAX_SLOTS);
        else                                 ws = WW'(r_win);
    end

    assign base_len = clamp_len(r_base, r_total);
    assign st_sum   = {1'b0, r_base} + 33'(SEGMENT_BYTES);
    assign st_new   = st_sum[32] ? 32'hFFFF_FFFF : st_sum[31:0];
    assign st_len   = clamp_len(st_new, r_total);
    assign slide_sel = (23'(r_lead) > r_segs) ? WW'(r_segs) : r_lead;

    always_comb begin
        o_stat.op         = r_op;
        o_stat.out_busy   = o_valid;
        o_stat.last_idx   = (WW'(r_idx) == ws - WW'(1));
        o_stat.clr_last   = (r_idx == IW'(MAX_SLOTS - 1));
        o_stat.in_win     = (CW'(r_sstart[5:0]) < CW'(ws));
        o_stat.match      = (r_rd.off == r_sstart) && (r_rd.len == r_slen) &&
                            ((r_rd.st == ST_NOT_ACTIVE) || (r_rd.st == ST_SENT));
        o_stat.saved      = (r_rd.st == ST_SAVED);
        o_stat.received   = (r_rd.st == ST_RECEIVED);
        o_stat.eligible   = (r_rd.st == ST_NOT_ACTIVE) || (r_rd.st == ST_SENT);
        o_stat.lead_zero  = (r_lead == WW'(0));
        o_stat.cp_copy    = ((WW+1)'(r_idx) + (WW+1)'(r_slide)) < (WW+1)'(ws);
        o_stat.pend_valid = r_pend_valid;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_rd;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        case (i_uop)
            UOP_CLR: begin
                wr_en   = 1'b1;
                wr_data = '0;
            end
            UOP_INIT_WR: begin
                wr_en   = 1'b1;
                wr_data = '{off: r_base, len: base_len, st: ST_NOT_ACTIVE};
            end
            UOP_RD: rd_en = 1'b1;
            UOP_RD_SRC: begin
                rd_en   = 1'b1;
                rd_addr = IW'((WW+1)'(r_idx) + (WW+1)'(r_slide));
            end
            UOP_RCV_HIT: begin
                wr_en      = 1'b1;
                wr_data.st = ST_RECEIVED;
            end
            UOP_SAVE_HIT: begin
                wr_en      = 1'b1;
                wr_data.st = ST_SAVED;
            end
            UOP_CP_WR: wr_en = 1'b1;
            UOP_NEW_WR: begin
                wr_en   = 1'b1;
                wr_data = '{off: st_new, len: st_len, st: ST_NOT_ACTIVE};
            end
            UOP_Q_HIT: begin
                wr_en      = 1'b1;
                wr_data.st = ST_SENT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        push_en    = 1'b0;
        push_kind  = kind_of(r_op);
        push_hit   = r_res_hit;
        push_slot  = 6'(r_res_slot);
        push_start = 32'd0;
        push_len   = 10'd0;
        push_slide = (r_op == OP_SLIDE) ? 7'(r_slide) : 7'd0;
        push_last  = 1'b1;
        case (i_uop)
            UOP_EMIT_LAST: push_en = 1'b1;
            UOP_Q_HIT, UOP_PEND_LAST: begin
                push_en    = (i_uop == UOP_PEND_LAST) || r_pend_valid;
                push_kind  = KIND_REQ;
                push_hit   = 1'b1;
                push_slot  = 6'(r_pend_slot);
                push_start = r_pend_off;
                push_len   = r_pend_len;
                push_slide = 7'd0;
                push_last  = (i_uop == UOP_PEND_LAST);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 32'd0;
            r_win   <= 7'd64;
            r_segs  <= 23'd0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TOTAL: r_total <= i_cfg_data;
                    CFG_WIN:   r_win   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (push_en)      o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            case (i_uop)
                UOP_CAP: begin
                    if (i_opcode == OP_INIT) r_segs <= i_segment_count;
                    r_idx <= ((i_opcode == OP_SAVE) || (i_opcode == OP_REQ)) ?
                             IW'(i_slot_index) : '0;
                end
                UOP_CLR, UOP_INIT_WR, UOP_INC, UOP_LEAD_INC, UOP_CP_WR, UOP_NEW_WR,
                UOP_Q_HIT: r_idx <= r_idx + IW'(1);
                UOP_SL_SETUP: begin
                    r_segs <= r_segs - 23'(slide_sel);
                    r_idx  <= IW'(ws - WW'(1));
                end
                UOP_BASE_LD: r_idx <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_uop)
            UOP_CAP: begin
                r_op         <= i_opcode;
                r_sstart     <= ((i_opcode == OP_SAVE) || (i_opcode == OP_REQ)) ?
                                {26'd0, i_slot_index} : i_seg_start;
                r_slen       <= i_seg_length;
                r_lead       <= '0;
                r_slide      <= '0;
                r_base       <= 32'd0;
                r_res_hit    <= 1'b0;
                r_res_slot   <= '0;
                r_pend_valid <= 1'b0;
            end
            UOP_INIT_WR: r_base <= r_base + 32'(base_len);
            UOP_RCV_HIT, UOP_SAVE_HIT: begin
                r_res_hit  <= 1'b1;
                r_res_slot <= r_idx;
            end
            UOP_LEAD_INC: r_lead <= r_lead + WW'(1);
            UOP_SL_SETUP: r_slide <= slide_sel;
            UOP_BASE_LD: r_base <= r_rd.off;
            UOP_NEW_WR: r_base <= r_base + 32'(st_len);
            UOP_Q_HIT: begin
                r_pend_valid <= 1'b1;
                r_pend_slot  <= r_idx;
                r_pend_off   <= r_rd.off;
                r_pend_len   <= r_rd.len;
            end
            default: ;
        endcase
        if (push_en) begin
            o_result_kind        <= push_kind;
            o_hit                <= push_hit;
            o_hit_slot           <= push_slot;
            o_req_start          <= push_start;
            o_req_length         <= push_len;
            o_slide_amount       <= push_slide;
            o_segments_remaining <= r_segs;
            o_last               <= push_last;
        end
    end

endmodule
